// File: design/hafr_pkg.sv
// ----------------------------------------------------------------------------
// hafr_pkg
// Types and constants shared by the HID APDU report framer.
// ----------------------------------------------------------------------------
package hafr_pkg;

  localparam int unsigned CFG_INDEX_W  = 8;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QUEUE_PTR_W  = 2;
  localparam int unsigned QUEUE_CNT_W  = 3;
  localparam int unsigned HEADER_BYTES = 5;
  localparam int unsigned LENGTH_BYTES = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_ID  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMMAND_TAG = 8'd1;

  localparam logic [15:0] CHANNEL_ID_RESET  = 16'h0101;
  localparam logic [7:0]  COMMAND_TAG_RESET = 8'h05;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] message_length;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] report_byte;
    logic       end_of_report;
    logic       end_of_message;
    logic       run_last;
  } out_item_t;

  // one classified input transaction
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] message_length;
    logic [15:0] channel_id;
    logic [7:0]  command_tag;
    logic [15:0] seq_no;
    logic        has_header;
    logic        has_length;
    logic        end_of_report;
    logic        end_of_message;
  } cmd_t;

  typedef enum logic [2:0] {
    STEP_CH_HI,
    STEP_CH_LO,
    STEP_TAG,
    STEP_SEQ_HI,
    STEP_SEQ_LO,
    STEP_LEN_HI,
    STEP_LEN_LO,
    STEP_DATA
  } step_t;

endpackage

// File: design/hafr_front.sv
// ----------------------------------------------------------------------------
// hafr_front
// Accepts message bytes, tracks report position and sequence number, and
// classifies each byte into a command for the byte sequencer.
// ----------------------------------------------------------------------------
module hafr_front import hafr_pkg::*; #(
  parameter int unsigned REPORT_BYTES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   queue_full,
  output logic                   push,
  output cmd_t                   push_cmd
);

  localparam int unsigned PosW = $clog2(REPORT_BYTES);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [15:0]     seq_r, seq_nxt;
  logic            in_msg_r, in_msg_nxt;
  logic [15:0]     channel_id_r, channel_id_nxt;
  logic [7:0]      command_tag_r, command_tag_nxt;

  logic            hdr;
  logic            first;
  logic [PosW-1:0] pos_data;
  logic            eor;

  assign in_ready  = !queue_full;
  assign cfg_ready = 1'b1;
  assign push      = in_valid && in_ready;

  always_comb begin
    hdr      = (pos_r == '0);
    first    = !in_msg_r;
    pos_data = pos_r + (hdr ? PosW'(HEADER_BYTES) : '0) + (first ? PosW'(LENGTH_BYTES) : '0);
    eor      = in_item.last_byte || (pos_data == PosW'(REPORT_BYTES - 1));

    push_cmd.data_byte      = in_item.data_byte;
    push_cmd.message_length = in_item.message_length;
    push_cmd.channel_id     = channel_id_r;
    push_cmd.command_tag    = command_tag_r;
    push_cmd.seq_no         = seq_r;
    push_cmd.has_header     = hdr;
    push_cmd.has_length     = first;
    push_cmd.end_of_report  = eor;
    push_cmd.end_of_message = in_item.last_byte;

    pos_nxt    = pos_r;
    seq_nxt    = seq_r;
    in_msg_nxt = in_msg_r;
    if (push) begin
      pos_nxt    = eor ? '0 : pos_data + PosW'(1);
      seq_nxt    = in_item.last_byte ? '0 : seq_r + (hdr ? 16'd1 : 16'd0);
      in_msg_nxt = !in_item.last_byte;
    end

    channel_id_nxt  = channel_id_r;
    command_tag_nxt = command_tag_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CHANNEL_ID) begin
        channel_id_nxt = cfg_data;
      end
      if (cfg_index == CFG_COMMAND_TAG) begin
        command_tag_nxt = cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      seq_r         <= '0;
      in_msg_r      <= 1'b0;
      channel_id_r  <= CHANNEL_ID_RESET;
      command_tag_r <= COMMAND_TAG_RESET;
    end else begin
      pos_r         <= pos_nxt;
      seq_r         <= seq_nxt;
      in_msg_r      <= in_msg_nxt;
      channel_id_r  <= channel_id_nxt;
      command_tag_r <= command_tag_nxt;
    end
  end

endmodule

// File: design/hafr_queue.sv
// ----------------------------------------------------------------------------
// hafr_queue
// Small command queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module hafr_queue import hafr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic empty,
  output cmd_t head
);

  cmd_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QUEUE_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (push ? QUEUE_CNT_W'(1) : '0) - (pop ? QUEUE_CNT_W'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: design/hafr_back.sv
// ----------------------------------------------------------------------------
// hafr_back
// Byte sequencer: expands each command into header, length and data bytes,
// one byte per cycle into the output register unless out_ready stalls it.
// ----------------------------------------------------------------------------
module hafr_back import hafr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      empty,
  input  cmd_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  step_t     step_r, step_nxt;
  logic      started_r, started_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  step_t     cur;
  logic      load;
  logic      done;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    if (started_r) begin
      cur = step_r;
    end else if (head.has_header) begin
      cur = STEP_CH_HI;
    end else if (head.has_length) begin
      cur = STEP_LEN_HI;
    end else begin
      cur = STEP_DATA;
    end

    load = !empty && (!out_valid_r || out_ready);
    done = (cur == STEP_DATA);
    pop  = load && done;

    out_item_nxt.end_of_report  = 1'b0;
    out_item_nxt.end_of_message = 1'b0;
    out_item_nxt.run_last       = 1'b0;
    step_nxt                    = step_r;
    unique case (cur)
      STEP_CH_HI: begin
        out_item_nxt.report_byte = head.channel_id[15:8];
        step_nxt                 = STEP_CH_LO;
      end
      STEP_CH_LO: begin
        out_item_nxt.report_byte = head.channel_id[7:0];
        step_nxt                 = STEP_TAG;
      end
      STEP_TAG: begin
        out_item_nxt.report_byte = head.command_tag;
        step_nxt                 = STEP_SEQ_HI;
      end
      STEP_SEQ_HI: begin
        out_item_nxt.report_byte = head.seq_no[15:8];
        step_nxt                 = STEP_SEQ_LO;
      end
      STEP_SEQ_LO: begin
        out_item_nxt.report_byte = head.seq_no[7:0];
        step_nxt                 = head.has_length ? STEP_LEN_HI : STEP_DATA;
      end
      STEP_LEN_HI: begin
        out_item_nxt.report_byte = head.message_length[15:8];
        step_nxt                 = STEP_LEN_LO;
      end
      STEP_LEN_LO: begin
        out_item_nxt.report_byte = head.message_length[7:0];
        step_nxt                 = STEP_DATA;
      end
      STEP_DATA: begin
        out_item_nxt.report_byte    = head.data_byte;
        out_item_nxt.end_of_report  = head.end_of_report;
        out_item_nxt.end_of_message = head.end_of_message;
        out_item_nxt.run_last       = 1'b1;
        step_nxt                    = STEP_DATA;
      end
      default: begin
        out_item_nxt.report_byte = head.data_byte;
      end
    endcase

    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      started_nxt   = !done;
    end else begin
      out_item_nxt = out_item_r;
      step_nxt     = step_r;
      if (out_ready) begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_DATA;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/hid_apdu_framer_unit.sv
// ----------------------------------------------------------------------------
// hid_apdu_framer_unit
// Frames APDU message bytes into HID reports with channel, tag, sequence
// and first-report length header fields.
// ----------------------------------------------------------------------------
// The block takes one message byte per transaction and produces one output
// byte per cycle while out_ready is high. A byte in the middle of a report
// yields one output byte; a byte that opens a report yields six (5-byte
// header plus data), and the first byte of a message yields eight (header,
// 2-byte length, data). The output byte sequencer sets the sustained rate,
// so inputs flow one per cycle except while header and length bytes are
// being emitted. A four-entry command queue separates input acceptance from
// the sequencer, so input transactions keep being taken while results wait
// on out_ready, until the queue fills. Configuration registers (index 0
// channel id, index 1 command tag) are sampled when a byte is accepted.
module hid_apdu_framer_unit import hafr_pkg::*; #(
  parameter int unsigned REPORT_BYTES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  logic full;
  logic empty;
  cmd_t head;

  hafr_front #(
    .REPORT_BYTES(REPORT_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .queue_full(full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  hafr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .full    (full),
    .empty   (empty),
    .head    (head)
  );

  hafr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

// File: design/hafr_checker.sv
// ----------------------------------------------------------------------------
// hafr_checker
// Port-level checks on the framer output stream.
// ----------------------------------------------------------------------------
module hafr_checker import hafr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output transaction changed while stalled");

  a_eom_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.end_of_message |-> out_item.end_of_report)
    else $error("end of message without end of report");

  // report and message ends only fall on data bytes
  a_eor_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.end_of_report |-> out_item.run_last)
    else $error("end of report on a header or length byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind hid_apdu_framer_unit hafr_checker u_hafr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

// File: dv/hafr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hafr_scoreboard
// Watches the framer's input, output and register channels. Every accepted
// message byte is framed into the report bytes it should cause, and these
// are compared field by field with the output transactions in order.
// ----------------------------------------------------------------------------
module hafr_scoreboard import hafr_pkg::*; #(
  parameter int unsigned REPORT_BYTES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_item,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_item,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     pending
);

  logic [15:0] chan_id;
  logic [7:0]  cmd_tag;
  logic [5:0]  report_pos;
  logic [15:0] seq_num;
  logic        msg_open;
  out_item_t   report_bytes_q [$];
  out_item_t   want_byte;
  int          byte_no;

  task automatic report_error(input string msg);
    if (errors < 40) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    errors++;
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic eor, input logic eom,
                                    input logic fin);
    out_item_t r;
    r.report_byte    = b;
    r.end_of_report  = eor;
    r.end_of_message = eom;
    r.run_last       = fin;
    report_bytes_q.push_back(r);
    report_pos = report_pos + 6'd1;
  endfunction

  // bytes caused by one message byte: header at report start, length on first byte, data
  task automatic frame_byte(input in_item_t b);
    logic first;
    logic eor;
    first = !msg_open;
    if (report_pos == 6'd0) begin
      push_byte(chan_id[15:8], 1'b0, 1'b0, 1'b0);
      push_byte(chan_id[7:0], 1'b0, 1'b0, 1'b0);
      push_byte(cmd_tag, 1'b0, 1'b0, 1'b0);
      push_byte(seq_num[15:8], 1'b0, 1'b0, 1'b0);
      push_byte(seq_num[7:0], 1'b0, 1'b0, 1'b0);
      seq_num = seq_num + 16'd1;
    end
    if (first) begin
      push_byte(b.message_length[15:8], 1'b0, 1'b0, 1'b0);
      push_byte(b.message_length[7:0], 1'b0, 1'b0, 1'b0);
      msg_open = 1'b1;
    end
    eor = b.last_byte || (int'(report_pos) + 1 >= int'(REPORT_BYTES));
    push_byte(b.data_byte, eor, b.last_byte, 1'b1);
    if (eor) begin
      report_pos = 6'd0;
    end
    if (b.last_byte) begin
      seq_num  = 16'd0;
      msg_open = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      chan_id    = CHANNEL_ID_RESET;
      cmd_tag    = COMMAND_TAG_RESET;
      report_pos = 6'd0;
      seq_num    = 16'd0;
      msg_open   = 1'b0;
      byte_no    = 0;
      errors     = 0;
      report_bytes_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CHANNEL_ID) begin
          chan_id = cfg_data;
        end else if (cfg_index == CFG_COMMAND_TAG) begin
          cmd_tag = cfg_data[7:0];
        end
      end
      if (in_valid && in_ready) begin
        frame_byte(in_item);
      end
      if (out_valid && out_ready) begin
        if (report_bytes_q.size() == 0) begin
          report_error($sformatf("output byte %0d (%02h) with nothing expected",
                                 byte_no, out_item.report_byte));
        end else begin
          want_byte = report_bytes_q.pop_front();
          if (out_item.report_byte !== want_byte.report_byte) begin
            report_error($sformatf("byte %0d report_byte got %02h want %02h", byte_no,
                                   out_item.report_byte, want_byte.report_byte));
          end
          if (out_item.end_of_report !== want_byte.end_of_report) begin
            report_error($sformatf("byte %0d end_of_report got %b want %b", byte_no,
                                   out_item.end_of_report, want_byte.end_of_report));
          end
          if (out_item.end_of_message !== want_byte.end_of_message) begin
            report_error($sformatf("byte %0d end_of_message got %b want %b", byte_no,
                                   out_item.end_of_message, want_byte.end_of_message));
          end
          if (out_item.run_last !== want_byte.run_last) begin
            report_error($sformatf("byte %0d run_last got %b want %b", byte_no,
                                   out_item.run_last, want_byte.run_last));
          end
        end
        byte_no++;
      end
    end
    pending <= report_bytes_q.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the HID APDU report framer: directed edge messages, then
// random messages of mixed sizes across several register settings, with
// random idle on both channels and long output stalls.
// ----------------------------------------------------------------------------
module tb import hafr_pkg::*; ();

  localparam int unsigned RPT_BYTES = 64;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = CFG_COMMAND_TAG + 1'b1;
  localparam int FIRST_DATA = RPT_BYTES - HEADER_BYTES - LENGTH_BYTES;
  localparam int NEXT_DATA  = RPT_BYTES - HEADER_BYTES;
  localparam int HOLD_CYCLES = 400;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     errors;
  int                     pending;

  logic        steady = 1'b0;
  int          msg_left = 0;
  logic [15:0] msg_len_field = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  hid_apdu_framer_unit #(.REPORT_BYTES(RPT_BYTES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hafr_scoreboard #(.REPORT_BYTES(RPT_BYTES)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  task automatic send_byte(input logic [7:0] d, input logic [15:0] len, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid                <= 1'b1;
    in_item.data_byte      <= d;
    in_item.message_length <= len;
    in_item.last_byte      <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic start_message();
    int size;
    case ($urandom_range(0, 9))
      0: size = $urandom_range(NEXT_DATA + FIRST_DATA + 1, 150);
      1, 2: size = $urandom_range(21, NEXT_DATA + FIRST_DATA);
      3: size = FIRST_DATA + $urandom_range(0, 2) + NEXT_DATA * $urandom_range(0, 1);
      default: size = $urandom_range(1, 20);
    endcase
    msg_left = size;
    case ($urandom_range(0, 9))
      0: msg_len_field = 16'($urandom);
      1: msg_len_field = 16'h0000;
      2: msg_len_field = 16'hFFFF;
      default: msg_len_field = 16'(size);
    endcase
  endtask

  // n message bytes; a message may run on past the end of the call
  task automatic send_stream(input int n);
    int i;
    logic fresh;
    logic [15:0] len;
    for (i = 0; i < n; i++) begin
      fresh = 1'b0;
      if (msg_left == 0) begin
        start_message();
        fresh = 1'b1;
      end
      len = (fresh || $urandom_range(0, 1)) ? msg_len_field : 16'($urandom);
      send_byte(8'($urandom), len, msg_left == 1);
      msg_left--;
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [15:0] ch, input logic [7:0] tg);
    write_reg(CFG_CHANNEL_ID, ch);
    write_reg(CFG_COMMAND_TAG, {8'($urandom), tg});
    write_reg(CFG_INDEX_W'($urandom_range(CFG_FIRST_UNUSED, 2 ** CFG_INDEX_W - 1)),
              16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // output side: random stalls, quiet stretches and two long holds
  initial begin : report_sink
    int hold;
    int taken;
    logic relaxed;
    taken   = 0;
    relaxed = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 100 == 0) begin
        relaxed = ($urandom_range(0, 2) == 0);
      end
      if (taken == 200 || taken == 900) begin
        hold = HOLD_CYCLES;
      end else begin
        hold = relaxed ? 0 : $urandom_range(0, 6);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    int p;
    logic [15:0] ch;
    logic [7:0] tg;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values; zero and full length fields, one-byte messages
    send_byte(8'h00, 16'h0000, 1'b1);
    send_byte(8'hFF, 16'hFFFF, 1'b1);
    // length only taken from the first byte
    send_byte(8'h80, 16'h00A5, 1'b0);
    send_byte(8'h7F, 16'h5A5A, 1'b0);
    send_byte(8'h01, 16'hFFFF, 1'b0);
    send_byte(8'hFE, 16'h0000, 1'b1);
    // length field disagrees with the byte count
    send_byte(8'h55, 16'h1234, 1'b0);
    send_byte(8'hAA, 16'h0001, 1'b0);
    send_byte(8'h3C, 16'hEDCB, 1'b1);

    for (p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0: begin
          ch = 16'h0000;
          tg = 8'h00;
        end
        1: begin
          ch = 16'hFFFF;
          tg = 8'hFF;
        end
        5: begin
          ch = CHANNEL_ID_RESET;
          tg = COMMAND_TAG_RESET;
        end
        default: begin
          ch = 16'($urandom);
          tg = 8'($urandom);
        end
      endcase
      configure(ch, tg);
      steady = (p % 3 == 2);
      send_stream(76);
    end
    steady = 1'b0;
    wait_drained();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
